// File: rtl/core/mppg_pkg.sv
// Shared types and constants for the masked pixel premultiply block.
// No dependencies; used by masked_pixel_premultiply_gamma2.
`default_nettype none

package mppg_pkg;

  // Word and channel widths.
  localparam int unsigned PixW    = 32;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned ShiftW  = $clog2(PixW);
  localparam int unsigned NumChan = 3;

  // Widths along the arithmetic path.
  localparam int unsigned CcW  = 2 * ChanW;          // c*c
  localparam int unsigned CcaW = 3 * ChanW;          // c*c*a
  localparam int unsigned RhsW = CcaW + 2;           // 4*c*c*a
  localparam int unsigned OddW = ChanW + 1;          // 2n+1
  localparam int unsigned SqW  = 2 * OddW;           // (2n+1)^2
  localparam int unsigned LhsW = SqW + ChanW;        // 255*(2n+1)^2

  // One root bit is resolved per pipeline stage.
  localparam int unsigned RootSteps = ChanW;

  // Configuration port.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegRedMask   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegGreenMask = 2'd1;
  localparam logic [CfgIdxW-1:0] RegBlueMask  = 2'd2;

  localparam logic [PixW-1:0] RedMaskReset   = 32'h00FF_0000;
  localparam logic [PixW-1:0] GreenMaskReset = 32'h0000_FF00;
  localparam logic [PixW-1:0] BlueMaskReset  = 32'h0000_00FF;

  typedef logic [ChanW-1:0]  chan_t;
  typedef logic [PixW-1:0]   pix_t;
  typedef logic [ShiftW-1:0] shift_t;
  typedef logic [RhsW-1:0]   rhs_t;

  // Position of the lowest set bit of a mask; zero when the mask is empty.
  function automatic shift_t low_bit_pos(input pix_t mask);
    pix_t   lowest;
    shift_t pos;
    lowest = mask & (~mask + pix_t'(1));
    pos    = '0;
    for (int unsigned j = 0; j < ShiftW; j++) begin
      for (int unsigned i = 0; i < PixW; i++) begin
        if (((i >> j) & 1) != 0) begin
          pos[j] = pos[j] | lowest[i];
        end
      end
    end
    return pos;
  endfunction

  // Eight bits of a word taken at a shift.
  function automatic chan_t take_chan(input pix_t word, input shift_t sh);
    pix_t shifted;
    shifted = word >> sh;
    return shifted[ChanW-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/masked_pixel_premultiply_gamma2.sv
// Masked pixel premultiply in gamma-2 space, fully pipelined.
// done_o rises once a word has passed the stage 1, stage 2, root-search and output registers.
// Throughput: one word per clock; busy_o stays low and the receiver cannot stall.
// The depth is set by the square-root search, one result bit per stage.
// Reset (rst_ni low) restores the default masks and clears all valid bits.
// Depends on mppg_pkg.
`default_nettype none

module masked_pixel_premultiply_gamma2 (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [mppg_pkg::PixW-1:0]     src_pixel_i,
  output logic                               done_o,
  output logic [mppg_pkg::PixW-1:0]          dst_pixel_o,
  output logic                               mask_error_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [mppg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [mppg_pkg::PixW-1:0]     cfg_wdata_i
);

  localparam int unsigned NumChan   = mppg_pkg::NumChan;
  localparam int unsigned RootSteps = mppg_pkg::RootSteps;

  // Configuration registers.
  mppg_pkg::pix_t red_mask_q, green_mask_q, blue_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_mask_q   <= mppg_pkg::RedMaskReset;
      green_mask_q <= mppg_pkg::GreenMaskReset;
      blue_mask_q  <= mppg_pkg::BlueMaskReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mppg_pkg::RegRedMask:   red_mask_q   <= cfg_wdata_i;
        mppg_pkg::RegGreenMask: green_mask_q <= cfg_wdata_i;
        mppg_pkg::RegBlueMask:  blue_mask_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The pipeline never stalls, so a new word is always welcome.
  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // Channel shifts and the empty-mask check follow the mask registers.
  mppg_pkg::pix_t   alpha_mask;
  mppg_pkg::shift_t sh_r, sh_g, sh_b, sh_a;
  logic             mask_err;

  assign alpha_mask = ~(red_mask_q | green_mask_q | blue_mask_q);
  assign sh_r = mppg_pkg::low_bit_pos(red_mask_q);
  assign sh_g = mppg_pkg::low_bit_pos(green_mask_q);
  assign sh_b = mppg_pkg::low_bit_pos(blue_mask_q);
  assign sh_a = mppg_pkg::low_bit_pos(alpha_mask);
  assign mask_err = (red_mask_q == '0) || (green_mask_q == '0) ||
                    (blue_mask_q == '0) || (alpha_mask == '0);

  // Stage 1: extract the four channel bytes.
  logic                 s1_vld_q;
  mppg_pkg::chan_t      s1_col_q [NumChan];
  mppg_pkg::chan_t      s1_a_q;
  logic                 s1_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_col_q[0] <= mppg_pkg::take_chan(src_pixel_i, sh_b);
    s1_col_q[1] <= mppg_pkg::take_chan(src_pixel_i, sh_g);
    s1_col_q[2] <= mppg_pkg::take_chan(src_pixel_i, sh_r);
    s1_a_q      <= mppg_pkg::take_chan(src_pixel_i, sh_a);
    s1_err_q    <= mask_err;
  end

  // Stage 2: square each colour.
  logic                        s2_vld_q;
  logic [mppg_pkg::CcW-1:0]    s2_cc_q [NumChan];
  mppg_pkg::chan_t             s2_a_q;
  logic                        s2_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int unsigned ch = 0; ch < NumChan; ch++) begin
      s2_cc_q[ch] <= mppg_pkg::CcW'(s1_col_q[ch]) * mppg_pkg::CcW'(s1_col_q[ch]);
    end
    s2_a_q   <= s1_a_q;
    s2_err_q <= s1_err_q;
  end

  // Stage 3: scale by alpha to form 4*c*c*a, the target of the root search.
  logic                 root_vld_q [RootSteps];
  mppg_pkg::chan_t      root_n_q   [RootSteps][NumChan];
  mppg_pkg::rhs_t       root_rhs_q [RootSteps][NumChan];
  mppg_pkg::chan_t      root_a_q   [RootSteps];
  logic                 root_err_q [RootSteps];
  mppg_pkg::chan_t      root_nxt   [RootSteps][NumChan];

  logic [mppg_pkg::CcaW-1:0] cca [NumChan];

  always_comb begin
    for (int unsigned ch = 0; ch < NumChan; ch++) begin
      cca[ch] = mppg_pkg::CcaW'(s2_cc_q[ch]) * mppg_pkg::CcaW'(s2_a_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_vld_q[0] <= 1'b0;
    end else begin
      root_vld_q[0] <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int unsigned ch = 0; ch < NumChan; ch++) begin
      root_n_q[0][ch]   <= '0;
      root_rhs_q[0][ch] <= {cca[ch], 2'b00};
    end
    root_a_q[0]   <= s2_a_q;
    root_err_q[0] <= s2_err_q;
  end

  // Root search: each stage tries the next lower bit of n and keeps it when
  // 255*(2t-1)^2 <= 4*c*c*a, so n ends as the smallest value with
  // 255*(2n+1)^2 above the target.
  for (genvar s = 0; s < RootSteps; s++) begin : g_step
    localparam int unsigned BitPos = RootSteps - 1 - s;

    for (genvar ch = 0; ch < NumChan; ch++) begin : g_chan
      mppg_pkg::chan_t             trial;
      logic [mppg_pkg::OddW-1:0]   odd;
      logic [mppg_pkg::SqW-1:0]    sq;
      logic [mppg_pkg::LhsW-1:0]   lhs;

      always_comb begin
        trial = root_n_q[s][ch] | (mppg_pkg::chan_t'(1) << BitPos);
        odd   = {trial, 1'b0} - mppg_pkg::OddW'(1);
        sq    = mppg_pkg::SqW'(odd) * mppg_pkg::SqW'(odd);
        lhs   = {sq, 8'd0} - mppg_pkg::LhsW'(sq);
        root_nxt[s][ch] = (mppg_pkg::RhsW'(lhs) <= root_rhs_q[s][ch]) ?
                          trial : root_n_q[s][ch];
      end
    end

    if (s < RootSteps - 1) begin : g_reg
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          root_vld_q[s+1] <= 1'b0;
        end else begin
          root_vld_q[s+1] <= root_vld_q[s];
        end
      end

      always_ff @(posedge clk_i) begin
        for (int unsigned ch = 0; ch < NumChan; ch++) begin
          root_n_q[s+1][ch]   <= root_nxt[s][ch];
          root_rhs_q[s+1][ch] <= root_rhs_q[s][ch];
        end
        root_a_q[s+1]   <= root_a_q[s];
        root_err_q[s+1] <= root_err_q[s];
      end
    end
  end

  // Output register: pack A,R,G,B and strobe the word for one cycle.
  logic            done_q;
  mppg_pkg::pix_t  dst_pixel_q;
  logic            mask_error_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= root_vld_q[RootSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    dst_pixel_q  <= {root_a_q[RootSteps-1],
                     root_nxt[RootSteps-1][2],
                     root_nxt[RootSteps-1][1],
                     root_nxt[RootSteps-1][0]};
    mask_error_q <= root_err_q[RootSteps-1];
  end

  assign done_o       = done_q;
  assign dst_pixel_o  = dst_pixel_q;
  assign mask_error_o = mask_error_q;

endmodule

`default_nettype wire
